@@ sv/nrmc_pkg.sv @@
// shared types and constants of the nmea rmc sentence parser
package nrmc_pkg;

  // received characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;

  // record kinds
  localparam logic [1:0] KIND_LAT = 2'd0;
  localparam logic [1:0] KIND_LON = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;

  // field numbers (commas seen so far)
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_MAX    = 4'd15;

  // sentence type letter positions
  localparam logic [8:0] POS_TYPE_FIRST = 9'd4;
  localparam logic [8:0] POS_TYPE_MID   = 9'd5;
  localparam logic [8:0] POS_TYPE_LAST  = 9'd6;

  // configuration registers
  localparam logic [0:0]  CFG_SENTENCE_TYPE = 1'd0;
  localparam logic [0:0]  CFG_MAX_LENGTH    = 1'd1;
  localparam logic [23:0] SENTENCE_TYPE_RST = 24'h524D43;
  localparam logic [7:0]  MAX_LENGTH_RST    = 8'd100;

  // speed: thousandths of a knot, saturating
  localparam logic [23:0] SPEED_CAP = 24'd999999;
  // km/h = knots * 37 / 20; the /5 step is a reciprocal multiply
  localparam logic [24:0] DIV5_MUL   = 25'd26843546;
  localparam int          DIV5_SHIFT = 27;

  // one result record
  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  char_code;
    logic        fix_valid;
    logic        north;
    logic        east;
    logic [20:0] speed_kmh_milli;
    logic        is_last;
  } rec_t;

endpackage

@@ sv/nrmc_ifs.sv @@
// handshake channels: received bytes in, records out
interface nrmc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  char_code;
  logic        fix_valid;
  logic        north;
  logic        east;
  logic [20:0] speed_kmh_milli;
  logic        is_last;

  modport source (output valid, output record_kind, output char_code, output fix_valid,
                  output north, output east, output speed_kmh_milli, output is_last,
                  input ready);
  modport sink (input valid, input record_kind, input char_code, input fix_valid,
                input north, input east, input speed_kmh_milli, input is_last,
                output ready);
endinterface

@@ sv/nrmc_parse.sv @@
// per-byte sentence state and record generation
module nrmc_parse import nrmc_pkg::*; #(
  parameter int unsigned FRAC_LIMIT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic [7:0]  rx_byte,
  input  logic [23:0] sentence_type,
  input  logic [7:0]  max_length,
  input  logic        out_free,
  output logic        go,
  output logic        res_valid,
  output rec_t        res
);

  localparam logic [1:0] FRAC_LIM = 2'(FRAC_LIMIT);

  // sentence state
  logic [7:0]  byte_position, byte_position_next;
  logic [1:0]  type_match_count, type_match_count_next;
  logic [3:0]  comma_count, comma_count_next;
  logic        status_invalid, status_invalid_next;
  logic        north_flag, north_flag_next;
  logic        east_flag, east_flag_next;
  logic [19:0] speed_value, speed_value_next;
  logic [1:0]  fraction_digits, fraction_digits_next;
  logic        point_seen, point_seen_next;
  logic        field_start, field_start_next;
  logic        speed_stop, speed_stop_next;
  // speed times 37, kept alongside the speed
  logic [25:0] spd37;
  logic [25:0] spd37_next;

  logic        has_result;
  logic [8:0]  pos;
  logic [7:0]  type_char;
  logic [3:0]  digit;
  logic        is_digit;
  logic [23:0] speed_sum;
  logic [1:0]  frac_inc;
  logic [48:0] div_prod;
  logic [20:0] kmh;

  // km/h in thousandths from the stored speed
  assign div_prod = 49'(spd37[25:2]) * 49'(DIV5_MUL);
  assign kmh      = div_prod[DIV5_SHIFT +: 21];

  assign pos      = {1'b0, byte_position} + 9'd1;
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = 4'(rx_byte - CH_ZERO);
  assign frac_inc = fraction_digits + 2'd1;

  // expected type letter at this position
  always_comb begin
    case (pos[2:0])
      3'd4:    type_char = sentence_type[23:16];
      3'd5:    type_char = sentence_type[15:8];
      default: type_char = sentence_type[7:0];
    endcase
  end

  // speed digit accumulation
  always_comb begin
    if (!point_seen) begin
      speed_sum = 24'(speed_value) * 24'd10 + 24'(digit) * 24'd1000;
    end else if (frac_inc == 2'd1) begin
      speed_sum = 24'(speed_value) + 24'(digit) * 24'd100;
    end else if (frac_inc == 2'd2) begin
      speed_sum = 24'(speed_value) + 24'(digit) * 24'd10;
    end else begin
      speed_sum = 24'(speed_value) + 24'(digit);
    end
  end

  // next state and record for the byte in the input register
  always_comb begin
    byte_position_next    = byte_position;
    type_match_count_next = type_match_count;
    comma_count_next      = comma_count;
    status_invalid_next   = status_invalid;
    north_flag_next       = north_flag;
    east_flag_next        = east_flag;
    speed_value_next      = speed_value;
    fraction_digits_next  = fraction_digits;
    point_seen_next       = point_seen;
    field_start_next      = field_start;
    speed_stop_next       = speed_stop;
    has_result            = 1'b0;
    res                   = '0;

    if (rx_byte == CH_DOLLAR || (rx_byte == CH_STAR && byte_position != 8'd0 &&
        pos < {1'b0, max_length} && pos > POS_TYPE_LAST && type_match_count == 2'd3)) begin
      // a new sentence or the end of one clears the sentence state
      type_match_count_next = '0;
      comma_count_next      = '0;
      status_invalid_next   = 1'b0;
      north_flag_next       = 1'b0;
      east_flag_next        = 1'b0;
      speed_value_next      = '0;
      fraction_digits_next  = '0;
      point_seen_next       = 1'b0;
      field_start_next      = 1'b0;
      speed_stop_next       = 1'b0;
      if (rx_byte == CH_DOLLAR) begin
        byte_position_next = (max_length > 8'd1) ? 8'd1 : 8'd0;
      end else begin
        byte_position_next  = 8'd0;
        has_result          = 1'b1;
        res.record_kind     = KIND_SUM;
        res.fix_valid       = !status_invalid;
        res.north           = !status_invalid && north_flag;
        res.east            = !status_invalid && east_flag;
        res.speed_kmh_milli = status_invalid ? 21'd0 : kmh;
        res.is_last         = 1'b1;
      end
    end else if (byte_position != 8'd0 && pos < {1'b0, max_length}) begin
      byte_position_next = pos[7:0];
      if (pos <= POS_TYPE_LAST) begin
        // type letters
        if (pos >= POS_TYPE_FIRST && rx_byte == type_char) begin
          type_match_count_next = type_match_count + 2'd1;
        end
      end else if (type_match_count == 2'd3) begin
        if (rx_byte == CH_COMMA) begin
          if (comma_count != FLD_MAX) begin
            comma_count_next = comma_count + 4'd1;
          end
          field_start_next = 1'b1;
        end else begin
          field_start_next = 1'b0;
          case (comma_count)
            FLD_STATUS: begin
              if (field_start && rx_byte == CH_V) begin
                status_invalid_next = 1'b1;
              end
            end
            FLD_LAT, FLD_LON: begin
              if (!status_invalid) begin
                has_result      = 1'b1;
                res.record_kind = (comma_count == FLD_LAT) ? KIND_LAT : KIND_LON;
                res.char_code   = rx_byte;
              end
            end
            FLD_NS: begin
              if (field_start) begin
                north_flag_next = (rx_byte == CH_N);
              end
            end
            FLD_EW: begin
              if (field_start) begin
                east_flag_next = (rx_byte == CH_E);
              end
            end
            FLD_SPEED: begin
              if (!speed_stop) begin
                if (is_digit) begin
                  if (!point_seen || fraction_digits < FRAC_LIM) begin
                    if (point_seen) begin
                      fraction_digits_next = frac_inc;
                    end
                    speed_value_next = (speed_sum > SPEED_CAP) ? SPEED_CAP[19:0]
                                                               : speed_sum[19:0];
                  end
                end else if (rx_byte == CH_POINT && !point_seen) begin
                  point_seen_next = 1'b1;
                end else begin
                  speed_stop_next = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign spd37_next = {1'b0, speed_value_next, 5'b0} + {4'b0, speed_value_next, 2'b0}
                    + {6'b0, speed_value_next};

  // the byte moves on unless its record has nowhere to go
  assign go        = byte_valid && (out_free || !has_result);
  assign res_valid = go && has_result;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      type_match_count <= '0;
      comma_count      <= '0;
      status_invalid   <= 1'b0;
      north_flag       <= 1'b0;
      east_flag        <= 1'b0;
      speed_value      <= '0;
      fraction_digits  <= '0;
      point_seen       <= 1'b0;
      field_start      <= 1'b0;
      speed_stop       <= 1'b0;
      spd37            <= '0;
    end else if (go) begin
      byte_position    <= byte_position_next;
      type_match_count <= type_match_count_next;
      comma_count      <= comma_count_next;
      status_invalid   <= status_invalid_next;
      north_flag       <= north_flag_next;
      east_flag        <= east_flag_next;
      speed_value      <= speed_value_next;
      fraction_digits  <= fraction_digits_next;
      point_seen       <= point_seen_next;
      field_start      <= field_start_next;
      speed_stop       <= speed_stop_next;
      spd37            <= spd37_next;
    end
  end

  // start byte clears the sentence
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    go && rx_byte == CH_DOLLAR |=> type_match_count == 2'd0 && comma_count == 4'd0 &&
      speed_value == 20'd0 && !status_invalid)
    else $error("start byte did not clear sentence state");

  // scaled copy of the speed stays in step
  a_spd37_tracks: assert property (@(posedge clk) disable iff (rst)
    spd37 == 26'(speed_value) * 26'd37)
    else $error("scaled speed out of step");

  // speed stays saturated
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    {4'b0, speed_value} <= SPEED_CAP)
    else $error("speed above cap");

  // records only leave for an open, matched sentence
  a_rec_matched: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> type_match_count == 2'd3 && byte_position != 8'd0)
    else $error("record from an unmatched sentence");

endmodule

@@ sv/nrmc_out_reg.sv @@
// result register between the parser and the record channel
module nrmc_out_reg import nrmc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  rec_t  res,
  output logic  out_free,
  nrmc_rec_if.source rec
);

  logic valid;
  rec_t data;

  assign out_free = !valid || rec.ready;

  // hold the record until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rec.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign rec.valid           = valid;
  assign rec.record_kind     = data.record_kind;
  assign rec.char_code       = data.char_code;
  assign rec.fix_valid       = data.fix_valid;
  assign rec.north           = data.north;
  assign rec.east            = data.east;
  assign rec.speed_kmh_milli = data.speed_kmh_milli;
  assign rec.is_last         = data.is_last;

endmodule

@@ sv/nmea_rmc_sentence_parser.sv @@
// NMEA RMC sentence parser, top level
// Takes one received byte per item on rx and gives latitude/longitude character
// records and one summary record per matched sentence ending in a star on rec.
// A byte is taken every cycle unless the parse stage holds a byte whose record
// the output register cannot take. A record passes from the input register
// through the combinational parse stage, which forms the summary speed by one
// multiply by a reciprocal from a stored scaled speed, into the output register.
// No clearing pass after reset. Configuration (cfg_index 0: sentence type, 1: max
// length) is written by the user only while idle; the block does not enforce it.
module nmea_rmc_sentence_parser import nrmc_pkg::*; #(
  parameter int unsigned MAX_FRACTION_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  nrmc_byte_if.sink   rx,
  nrmc_rec_if.source  rec,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int unsigned FRAC_LIMIT = (MAX_FRACTION_DIGITS < 3) ? MAX_FRACTION_DIGITS : 3;

  logic [23:0] sentence_type;
  logic [7:0]  max_length;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        go;
  logic        res_valid;
  logic        out_free;
  rec_t        res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_type <= SENTENCE_TYPE_RST;
      max_length    <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SENTENCE_TYPE: sentence_type <= cfg_data;
        CFG_MAX_LENGTH:    max_length    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign rx.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  nrmc_parse #(
    .FRAC_LIMIT (FRAC_LIMIT)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (s1_valid),
    .rx_byte       (s1_byte),
    .sentence_type (sentence_type),
    .max_length    (max_length),
    .out_free      (out_free),
    .go            (go),
    .res_valid     (res_valid),
    .res           (res)
  );

  nrmc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .out_free (out_free),
    .rec      (rec)
  );

  // input stage only stalls when it holds a byte that cannot move
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> s1_valid && !out_free)
    else $error("input stalled without cause");

endmodule

@@ bench/nmea_rmc_sentence_parser_tb.sv @@
// testbench of the nmea rmc sentence parser: random sentences checked against a local predictor
`timescale 1ns / 100ps

module nmea_rmc_sentence_parser_tb;
  import nrmc_pkg::*;

  localparam int unsigned FRAC_DIGITS = 3;
  localparam int unsigned FRAC_KEPT = (FRAC_DIGITS < 3) ? FRAC_DIGITS : 3;
  localparam logic [7:0] MAX_LEN_LO = 8'd7;
  localparam logic [7:0] MAX_LEN_HI = 8'd255;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  nrmc_byte_if rx_ch ();
  nrmc_rec_if  rec_ch ();

  nmea_rmc_sentence_parser #(
    .MAX_FRACTION_DIGITS(FRAC_DIGITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .rec       (rec_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bytes waiting to be sent, records waiting to come out
  logic [7:0] byte_q [$];
  rec_t       record_q [$];
  int         send_idle_pct;
  int         stall_pct;
  int         err_count;

  // register copies and sentence state of the predictor
  logic [23:0] type_letters;
  logic [7:0]  max_len;
  logic [7:0]  sent_pos;
  logic [1:0]  match_cnt;
  logic [3:0]  comma_cnt;
  bit          stat_inv;
  bit          north_f;
  bit          east_f;
  int unsigned knots_milli;
  logic [1:0]  frac_cnt;
  bit          point_f;
  bit          fld_start;
  bit          speed_done;

  function automatic void clear_sentence();
    match_cnt   = '0;
    comma_cnt   = '0;
    stat_inv    = 0;
    north_f     = 0;
    east_f      = 0;
    knots_milli = 0;
    frac_cnt    = '0;
    point_f     = 0;
    fld_start   = 0;
    speed_done  = 0;
  endfunction

  // advance the sentence state by one byte; returns 1 when a record results
  function automatic bit parse_byte(input logic [7:0] c, output rec_t r);
    int unsigned nxt;
    int unsigned d;
    int unsigned v;
    bit          first;
    bit          ok;
    r = '0;
    if (c == CH_DOLLAR) begin
      clear_sentence();
      sent_pos = (max_len > 1) ? 8'd1 : 8'd0;
      return 0;
    end
    if (sent_pos == 0) return 0;
    nxt = sent_pos + 1;
    if (nxt >= max_len) return 0;
    sent_pos = nxt[7:0];

    // type letters at positions four to six
    if (nxt <= POS_TYPE_LAST) begin
      if (nxt >= POS_TYPE_FIRST && c == type_letters[(POS_TYPE_LAST - nxt) * 8 +: 8])
        match_cnt++;
      return 0;
    end
    if (match_cnt != 3) return 0;

    // end of sentence: summary
    if (c == CH_STAR) begin
      ok = !stat_inv;
      r.record_kind     = KIND_SUM;
      r.fix_valid       = ok;
      r.north           = ok && north_f;
      r.east            = ok && east_f;
      r.speed_kmh_milli = ok ? 21'((knots_milli * 185) / 100) : '0;
      r.is_last         = 1;
      sent_pos = '0;
      clear_sentence();
      return 1;
    end
    if (c == CH_COMMA) begin
      if (comma_cnt < FLD_MAX) comma_cnt++;
      fld_start = 1;
      return 0;
    end

    first = fld_start;
    fld_start = 0;
    case (comma_cnt)
      FLD_STATUS: begin
        if (first && c == CH_V) stat_inv = 1;
      end
      FLD_LAT: begin
        if (!stat_inv) begin
          r.record_kind = KIND_LAT;
          r.char_code   = c;
          return 1;
        end
      end
      FLD_NS: begin
        if (first) north_f = (c == CH_N);
      end
      FLD_LON: begin
        if (!stat_inv) begin
          r.record_kind = KIND_LON;
          r.char_code   = c;
          return 1;
        end
      end
      FLD_EW: begin
        if (first) east_f = (c == CH_E);
      end
      FLD_SPEED: begin
        // knots in thousandths, surplus fraction digits dropped
        if (!speed_done) begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            v = knots_milli;
            if (!point_f) begin
              v = knots_milli * 10 + d * 1000;
            end else if (frac_cnt < FRAC_KEPT) begin
              frac_cnt++;
              v = knots_milli + ((frac_cnt == 1) ? d * 100 : (frac_cnt == 2) ? d * 10 : d);
            end
            knots_milli = (v > SPEED_CAP) ? SPEED_CAP : v;
          end else if (c == CH_POINT && !point_f) begin
            point_f = 1;
          end else begin
            speed_done = 1;
          end
        end
      end
      default: ;
    endcase
    return 0;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // byte driver: predicts each accepted item, then offers the next one
  always @(posedge clk) begin
    rec_t exp_rec;
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        if (parse_byte(rx_ch.rx_byte, exp_rec)) record_q.push_back(exp_rec);
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= byte_q.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // record monitor with random back-pressure
  always @(posedge clk) begin
    rec_t got;
    rec_t want;
    if (rst) begin
      rec_ch.ready <= 1'b0;
    end else begin
      if (rec_ch.valid && rec_ch.ready) begin
        got.record_kind     = rec_ch.record_kind;
        got.char_code       = rec_ch.char_code;
        got.fix_valid       = rec_ch.fix_valid;
        got.north           = rec_ch.north;
        got.east            = rec_ch.east;
        got.speed_kmh_milli = rec_ch.speed_kmh_milli;
        got.is_last         = rec_ch.is_last;
        if (record_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected record: kind %0d char %02h valid %0b n %0b e %0b speed %0d last %0b",
                     got.record_kind, got.char_code, got.fix_valid, got.north, got.east,
                     got.speed_kmh_milli, got.is_last);
        end else begin
          want = record_q.pop_front();
          if (got !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("record mismatch at %0t", $realtime);
              $display("  expected: kind %0d char %02h valid %0b n %0b e %0b speed %0d last %0b",
                       want.record_kind, want.char_code, want.fix_valid, want.north, want.east,
                       want.speed_kmh_milli, want.is_last);
              $display("  actual:   kind %0d char %02h valid %0b n %0b e %0b speed %0d last %0b",
                       got.record_kind, got.char_code, got.fix_valid, got.north, got.east,
                       got.speed_kmh_milli, got.is_last);
            end
          end
        end
      end
      rec_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) byte_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  // any byte that does not delimit a sentence or a field
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic push_coord();
    int n;
    int r;
    n = $urandom_range(8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r == 0) byte_q.push_back(text_byte());
      else if (r == 1) byte_q.push_back(CH_POINT);
      else push_digits(1);
    end
  endtask

  task automatic push_speed();
    case ($urandom_range(9))
      0: ;
      1: begin
        // large enough to saturate
        for (int i = 0; i < $urandom_range(5, 8); i++) push_text("9");
        push_text(".9999");
      end
      2: begin
        push_digits($urandom_range(3));
        push_text(".");
        push_digits($urandom_range(2));
        push_text(".");
        push_digits($urandom_range(2));
      end
      3: begin
        push_digits($urandom_range(1, 3));
        byte_q.push_back(text_byte());
        push_digits($urandom_range(3));
      end
      default: begin
        push_digits($urandom_range(4));
        if ($urandom_range(9) < 7) begin
          push_text(".");
          push_digits($urandom_range(5));
        end
      end
    endcase
  endtask

  // one sentence, mostly well formed with random content
  task automatic add_sentence();
    logic [7:0] letters [3];
    string      hexd;
    int         r;
    int         nflds;
    hexd = "0123456789ABCDEF";
    for (int i = 0; i < 3; i++) letters[i] = type_letters[(2 - i) * 8 +: 8];
    r = $urandom_range(99);
    if (r >= 90) begin
      for (int i = 0; i < 3; i++) letters[i] = 8'($urandom_range(65, 90));
    end else if (r >= 80) begin
      letters[$urandom_range(2)] = 8'($urandom_range(65, 90));
    end
    byte_q.push_back(CH_DOLLAR);
    byte_q.push_back(8'($urandom_range(65, 90)));
    byte_q.push_back(8'($urandom_range(65, 90)));
    for (int i = 0; i < 3; i++) byte_q.push_back(letters[i]);

    nflds = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(7, 11);
    for (int f = 1; f <= nflds; f++) begin
      byte_q.push_back(CH_COMMA);
      case (f)
        FLD_STATUS: begin
          case ($urandom_range(5))
            0: push_text("A");
            1: push_text("V");
            2: ;
            3: push_text("VA");
            4: push_text("AV");
            default: byte_q.push_back(text_byte());
          endcase
        end
        FLD_LAT, FLD_LON: push_coord();
        FLD_NS: begin
          case ($urandom_range(4))
            0, 1: push_text("N");
            2: push_text("S");
            3: ;
            default: byte_q.push_back(text_byte());
          endcase
        end
        FLD_EW: begin
          case ($urandom_range(4))
            0, 1: push_text("E");
            2: push_text("W");
            3: ;
            default: byte_q.push_back(text_byte());
          endcase
        end
        FLD_SPEED: push_speed();
        default: push_digits($urandom_range(6));
      endcase
    end

    // checksum and line end, or a broken tail
    r = $urandom_range(99);
    if (r < 85) begin
      byte_q.push_back(CH_STAR);
      byte_q.push_back(hexd[$urandom_range(15)]);
      byte_q.push_back(hexd[$urandom_range(15)]);
      push_text("\r\n");
    end else if (r >= 93) begin
      for (int i = 0; i < $urandom_range(1, 3); i++) byte_q.push_back(text_byte());
    end
    // line noise between sentences
    if ($urandom_range(4) == 0) begin
      for (int i = 0; i < $urandom_range(1, 4); i++) byte_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // wait until all items are taken and all records are back, then let the pipe settle
  task automatic wait_drained();
    while (byte_q.size() != 0 || rx_ch.valid || record_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input logic [23:0] stype,
                           input logic [7:0] mlen, input int nbytes);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SENTENCE_TYPE;
    cfg_data  <= stype;
    type_letters = stype;
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= {16'h0, mlen};
    max_len = mlen;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (byte_q.size() < nbytes) add_sentence();
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SENTENCE_TYPE;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    rec_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    err_count     = 0;
    type_letters  = SENTENCE_TYPE_RST;
    max_len       = MAX_LENGTH_RST;
    sent_pos      = '0;
    clear_sentence();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: bytes with no sentence open, star in a type position,
    // valid fix with all fields, invalid fix with suppressed characters
    @(negedge clk);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    push_text("A$**RMC,,A,1,N,2,E,9.9*");
    push_text("$GPRMC,,V,3*");
    wait_drained();

    // random sentences over several register settings and idle patterns
    run_phase(0, 0, SENTENCE_TYPE_RST, MAX_LEN_HI, 90);
    run_phase(66, 0, 24'hFFFFFF, 8'd30, 90);
    run_phase(0, 66, 24'($urandom()), 8'($urandom_range(40, 255)), 90);
    run_phase(29, 29, 24'h000000, MAX_LEN_LO, 45);
    run_phase(29, 29, SENTENCE_TYPE_RST, MAX_LENGTH_RST, 90);

    if (err_count == 0) begin
      $display("nmea_rmc_sentence_parser verification clean");
    end else begin
      $display("nmea_rmc_sentence_parser verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("nmea_rmc_sentence_parser verification failed");
    $finish;
  end

endmodule
